/* design/arf_pkg.sv */
// shared constants, register indexes and helpers of the aitken relaxation block
`timescale 1ns / 1ps

package arf_pkg;

    localparam int ARF_MAX_DOFS = 4096;
    localparam int DOF_W        = 12;
    localparam int DATA_W       = 32;
    localparam int DIV_W        = 64;
    localparam int CFG_IDX_W    = 2;
    localparam int COUNT_W      = 13;
    localparam int RSUM_W       = 48;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_MODE          = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_RESTART       = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_RESTART_RELAX = 2'd2;

    // input function codes
    localparam logic FUNC_INIT = 1'b0;
    localparam logic FUNC_DOF  = 1'b1;

    localparam logic signed [63:0] ONE_Q30   = 64'sh0000_0000_4000_0000;
    localparam logic [63:0]        TWO_60    = 64'h1000_0000_0000_0000;
    localparam logic [63:0]        NU_CAP    = 64'h0000_0004_0000_0000;
    localparam logic signed [63:0] R48_MAX   = 64'sh0000_7FFF_FFFF_FFFF;
    localparam logic signed [63:0] R48_MIN   = -64'sh0000_8000_0000_0000;
    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        logic signed [31:0] r;
        if (v > 64'sh0000_0000_7FFF_FFFF)
            r = 32'sh7FFF_FFFF;
        else if (v < -64'sh0000_0000_8000_0000)
            r = 32'sh8000_0000;
        else
            r = v[31:0];
        return r;
    endfunction

endpackage

/* design/aitken_relaxation_factor.sv */
// top level: aitken dynamic relaxation factor with per-dof delta store
`timescale 1ns / 1ps

// Aitken relaxation factor for a coupling iteration. An init item (func = 0)
// loads nu and the held factor; each coupled dof item forms delta = relaxed -
// unrelaxed, swaps it with the stored delta of its dof and, without the start
// mark, accumulates the Aitken sums and the ratio sum; a dof item flagged last
// gives one result (mode 0: Aitken update, mode 1: 1/(1-mean ratio)). One item
// is worked on at a time. An init item or an uncoupled item that is not last
// ends in its accept cycle; a coupled dof item passes ram read and multiply,
// then, with no start mark, accumulate and, when the old delta is nonzero, a
// ratio division. A last item adds the result phase, whose divisions run on the
// shared one-bit-a-cycle divider and are skipped on a fault or a capped
// quotient, plus a wait while a previous result is not taken. The delta store
// has no clearing pass: it holds nothing until a first-iteration item writes it.
module aitken_relaxation_factor #(
    parameter int MAX_DOFS = arf_pkg::ARF_MAX_DOFS
) (
    input  logic                              clk,
    input  logic                              rst_n,
    // config port
    input  logic                              cfg_write,
    input  logic [arf_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [arf_pkg::DATA_W-1:0]        cfg_data,
    // input channel
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic                              func,
    input  logic signed [arf_pkg::DATA_W-1:0] relaxed_disp,
    input  logic signed [arf_pkg::DATA_W-1:0] unrelaxed_disp,
    input  logic [arf_pkg::DOF_W-1:0]         dof_index,
    input  logic                              coupled,
    input  logic                              first_iteration,
    input  logic                              last,
    // output channel
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic signed [arf_pkg::DATA_W-1:0] relax_factor,
    output logic                              divide_fault
);
    import arf_pkg::*;

    localparam int AW = $clog2(MAX_DOFS);

    // sequencer states
    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_RD    = 4'd1;   // old delta arrives, multiply
    localparam logic [3:0] S_ACC   = 4'd2;   // accumulate top and den
    localparam logic [3:0] S_RDIV  = 4'd3;   // ratio term division
    localparam logic [3:0] S_FIN   = 4'd4;   // last item: pick result path
    localparam logic [3:0] S_AM1   = 4'd5;   // low partial product
    localparam logic [3:0] S_AM2   = 4'd6;   // high partial product
    localparam logic [3:0] S_AM3   = 4'd7;   // combine, overflow check
    localparam logic [3:0] S_ADIV  = 4'd8;   // (nu-1)*top/den
    localparam logic [3:0] S_AFIN  = 4'd9;   // new nu
    localparam logic [3:0] S_M1DIV = 4'd10;  // mean ratio
    localparam logic [3:0] S_M2DIV = 4'd11;  // 1/(1-q)
    localparam logic [3:0] S_OUT   = 4'd12;  // hand result to output register

    logic [3:0] state_reg;

    // configuration
    logic               mode_reg;
    logic               restart_reg;
    logic signed [31:0] rr_reg;

    // iteration state
    logic signed [31:0]        nu_reg;
    logic signed [31:0]        held_reg;
    logic signed [63:0]        top_reg;
    logic [63:0]               den_reg;
    logic signed [RSUM_W-1:0]  rsum_reg;
    logic [COUNT_W-1:0]        cnt_reg;
    logic                      mark_reg;
    logic                      rfault_reg;

    // item being worked on
    logic signed [31:0] delta_reg;
    logic [AW-1:0]      addr_reg;
    logic               imark_reg;
    logic               ilast_reg;
    logic signed [31:0] old_reg;
    logic signed [64:0] ptop_reg;
    logic [63:0]        pden_reg;
    logic [31:0]        am_reg;
    logic [63:0]        tm_reg;
    logic [63:0]        p0_reg;
    logic [63:0]        p1_reg;
    logic [63:0]        q_reg;
    logic               neg_reg;
    logic signed [31:0] res_relax_reg;
    logic               res_fault_reg;

    // divider launch
    logic        dstart_reg;
    logic        dstart_next;
    logic [63:0] dhi_reg;
    logic [63:0] dlo_reg;
    logic [63:0] dden_reg;
    logic        div_done;
    logic [63:0] div_quo;

    // output register
    logic               out_valid_reg;
    logic signed [31:0] out_relax_reg;
    logic               out_fault_reg;

    logic [31:0] ram_rdata;
    logic        in_acc;
    logic        in_range;
    logic        can_load;

    // accept-cycle arithmetic
    logic signed [31:0] delta_in;
    logic signed [31:0] nu_init;
    logic signed [31:0] held_init;

    // dof path
    logic signed [31:0] old_w;
    logic signed [32:0] d2;
    logic [32:0]        d2m;
    logic signed [64:0] ptop_w;
    logic [63:0]        pden_w;
    logic signed [64:0] t_w;
    logic signed [65:0] tsum;
    logic signed [63:0] top_sat;
    logic [64:0]        dsum;
    logic [63:0]        den_sat;
    logic [32:0]        dm;
    logic [32:0]        om;
    logic signed [63:0] r_w;
    logic signed [RSUM_W-1:0] r48;
    logic signed [RSUM_W:0]   rs;
    logic signed [RSUM_W-1:0] rs_sat;

    // result path
    logic signed [33:0] a_w;
    logic [33:0]        am_w;
    logic [63:0]        tm_w;
    logic [63:0]        lo_w;
    logic [63:0]        hi_w;
    logic signed [35:0] s_w;
    logic signed [31:0] nu_new;
    logic signed [31:0] relax_a;
    logic signed [63:0] qm;
    logic signed [63:0] dd;
    logic [63:0]        ddm;
    logic signed [63:0] r2;
    logic [RSUM_W-1:0]  rsum_m;
    logic [63:0]        q_cap;

    arf_ram #(
        .WIDTH (DATA_W),
        .DEPTH (MAX_DOFS)
    ) u_delta_ram (
        .clk   (clk),
        .we    (state_reg == S_RD),
        .waddr (addr_reg),
        .wdata (delta_reg),
        .raddr (AW'(dof_index)),
        .rdata (ram_rdata)
    );

    arf_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (dstart_reg),
        .hi    (dhi_reg),
        .lo    (dlo_reg),
        .den   (dden_reg),
        .done  (div_done),
        .quo   (div_quo)
    );

    assign in_stall = (state_reg != S_IDLE);
    assign in_acc   = in_valid && !in_stall;
    assign in_range = (32'(dof_index) < 32'(MAX_DOFS));
    assign can_load = !out_valid_reg || !out_stall;

    always_comb
    begin
        delta_in  = sat32(64'(relaxed_disp) - 64'(unrelaxed_disp));
        nu_init   = restart_reg ? sat32(ONE_Q30 - 64'(rr_reg)) : 32'sd0;
        held_init = sat32(ONE_Q30 - 64'(nu_init));

        // old minus new, exact in 33 bits
        old_w  = $signed(ram_rdata);
        d2     = 33'(old_w) - 33'(delta_reg);
        d2m    = d2[32] ? 33'(-d2) : 33'(d2);
        ptop_w = 65'(d2) * 65'(delta_reg);
        pden_w = 64'(d2m[31:0]) * 64'(d2m[31:0]);

        // floor shift, saturating sums
        t_w     = ptop_reg >>> 16;
        tsum    = 66'(top_reg) + 66'(t_w);
        if (tsum[65:63] != 3'b000 && tsum[65:63] != 3'b111)
            top_sat = tsum[65] ? 64'sh8000_0000_0000_0000 : 64'sh7FFF_FFFF_FFFF_FFFF;
        else
            top_sat = tsum[63:0];
        dsum    = {1'b0, den_reg} + {17'd0, pden_reg[63:16]};
        den_sat = dsum[64] ? '1 : dsum[63:0];
        dm      = delta_reg[31] ? 33'(-33'(delta_reg)) : 33'(delta_reg);
        om      = old_reg[31] ? 33'(-33'(old_reg)) : 33'(old_reg);

        // ratio term, saturated to 48 bits then accumulated
        r_w = neg_reg ? -$signed(div_quo) : $signed(div_quo);
        if (r_w > R48_MAX)
            r48 = R48_MAX[RSUM_W-1:0];
        else if (r_w < R48_MIN)
            r48 = R48_MIN[RSUM_W-1:0];
        else
            r48 = r_w[RSUM_W-1:0];
        rs = (RSUM_W+1)'(rsum_reg) + (RSUM_W+1)'(r48);
        if (rs[RSUM_W] != rs[RSUM_W-1])
            rs_sat = rs[RSUM_W] ? R48_MIN[RSUM_W-1:0] : R48_MAX[RSUM_W-1:0];
        else
            rs_sat = rs[RSUM_W-1:0];

        // aitken update
        a_w  = 34'(nu_reg) - 34'(ONE_Q30);
        am_w = a_w[33] ? 34'(-a_w) : 34'(a_w);
        tm_w = top_reg[63] ? 64'(-top_reg) : 64'(top_reg);
        lo_w = p0_reg + {p1_reg[31:0], 32'd0};
        hi_w = {32'd0, p1_reg[63:32]} + 64'(lo_w < p0_reg);
        q_cap = (div_quo > NU_CAP) ? NU_CAP : div_quo;
        s_w  = neg_reg ? -$signed({1'b0, q_reg[34:0]}) : $signed({1'b0, q_reg[34:0]});
        nu_new  = sat32(64'(nu_reg) + 64'(s_w));
        relax_a = sat32(ONE_Q30 - 64'(nu_new));

        // averaged ratio
        rsum_m = rsum_reg[RSUM_W-1] ? RSUM_W'(-rsum_reg) : RSUM_W'(rsum_reg);
        qm  = neg_reg ? -$signed(div_quo) : $signed(div_quo);
        dd  = ONE_Q30 - qm;
        ddm = dd[63] ? 64'(-dd) : 64'(dd);
        r2  = neg_reg ? -$signed(div_quo) : $signed(div_quo);
    end

    // divider start pulse, one cycle in the state that launches a division
    always_comb
    begin
        case (state_reg)
            S_ACC:   dstart_next = (old_reg != 32'sd0);
            S_FIN:   dstart_next = mode_reg && !(rfault_reg || cnt_reg == '0);
            S_AM3:   dstart_next = (hi_w < den_reg);
            S_M1DIV: dstart_next = div_done && (dd != 64'sd0);
            default: dstart_next = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            mode_reg      <= 1'b0;
            restart_reg   <= 1'b0;
            rr_reg        <= '0;
            nu_reg        <= '0;
            held_reg      <= 32'(ONE_Q30);
            top_reg       <= '0;
            den_reg       <= '0;
            rsum_reg      <= '0;
            cnt_reg       <= '0;
            mark_reg      <= 1'b0;
            rfault_reg    <= 1'b0;
            dstart_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            dstart_reg <= dstart_next;

            if (cfg_write)
            begin
                case (cfg_index)
                    REG_MODE:          mode_reg    <= cfg_data[0];
                    REG_RESTART:       restart_reg <= cfg_data[0];
                    REG_RESTART_RELAX: rr_reg      <= $signed(cfg_data);
                    default:           ;
                endcase
            end

            // a result taken while the next one waits in S_OUT is replaced there
            if (out_valid_reg && !out_stall && state_reg != S_OUT)
            begin
                out_valid_reg <= 1'b0;
            end

            case (state_reg)
                S_IDLE:
                begin
                    if (in_acc)
                    begin
                        delta_reg <= delta_in;
                        addr_reg  <= AW'(dof_index);
                        imark_reg <= first_iteration;
                        ilast_reg <= last;
                        if (func == FUNC_INIT)
                        begin
                            nu_reg     <= nu_init;
                            held_reg   <= held_init;
                            top_reg    <= '0;
                            den_reg    <= '0;
                            rsum_reg   <= '0;
                            cnt_reg    <= '0;
                            mark_reg   <= 1'b0;
                            rfault_reg <= 1'b0;
                        end
                        else if (coupled && in_range)
                            state_reg <= S_RD;
                        else if (last)
                            state_reg <= S_FIN;
                    end
                end

                S_RD:
                begin
                    if (cnt_reg != COUNT_MAX)
                        cnt_reg <= cnt_reg + 1'b1;
                    old_reg  <= old_w;
                    ptop_reg <= ptop_w;
                    pden_reg <= pden_w;
                    if (imark_reg)
                    begin
                        mark_reg  <= 1'b1;
                        state_reg <= ilast_reg ? S_FIN : S_IDLE;
                    end
                    else
                        state_reg <= S_ACC;
                end

                S_ACC:
                begin
                    top_reg <= top_sat;
                    den_reg <= den_sat;
                    if (old_reg == 32'sd0)
                    begin
                        rfault_reg <= 1'b1;
                        state_reg  <= ilast_reg ? S_FIN : S_IDLE;
                    end
                    else
                    begin
                        dhi_reg    <= '0;
                        dlo_reg    <= 64'(dm[31:0]) << 30;
                        dden_reg   <= 64'(om[31:0]);
                        neg_reg    <= delta_reg[31] ^ old_reg[31];
                        state_reg  <= S_RDIV;
                    end
                end

                S_RDIV:
                begin
                    if (div_done)
                    begin
                        rsum_reg  <= rs_sat;
                        state_reg <= ilast_reg ? S_FIN : S_IDLE;
                    end
                end

                S_FIN:
                begin
                    if (!mode_reg)
                    begin
                        if (mark_reg)
                        begin
                            res_relax_reg <= sat32(ONE_Q30 - 64'(nu_reg));
                            res_fault_reg <= 1'b0;
                            state_reg     <= S_OUT;
                        end
                        else if (den_reg == '0)
                        begin
                            res_relax_reg <= held_reg;
                            res_fault_reg <= 1'b1;
                            state_reg     <= S_OUT;
                        end
                        else
                        begin
                            am_reg    <= am_w[31:0];
                            tm_reg    <= tm_w;
                            neg_reg   <= a_w[33] ^ top_reg[63];
                            state_reg <= S_AM1;
                        end
                    end
                    else if (rfault_reg || cnt_reg == '0)
                    begin
                        res_relax_reg <= held_reg;
                        res_fault_reg <= 1'b1;
                        state_reg     <= S_OUT;
                    end
                    else
                    begin
                        dhi_reg    <= '0;
                        dlo_reg    <= 64'(rsum_m);
                        dden_reg   <= 64'(cnt_reg);
                        neg_reg    <= rsum_reg[RSUM_W-1];
                        state_reg  <= S_M1DIV;
                    end
                end

                S_AM1:
                begin
                    p0_reg    <= 64'(am_reg) * 64'(tm_reg[31:0]);
                    state_reg <= S_AM2;
                end

                S_AM2:
                begin
                    p1_reg    <= 64'(am_reg) * 64'(tm_reg[63:32]);
                    state_reg <= S_AM3;
                end

                S_AM3:
                begin
                    if (hi_w >= den_reg)
                    begin
                        q_reg     <= NU_CAP;
                        state_reg <= S_AFIN;
                    end
                    else
                    begin
                        dhi_reg    <= hi_w;
                        dlo_reg    <= lo_w;
                        dden_reg   <= den_reg;
                        state_reg  <= S_ADIV;
                    end
                end

                S_ADIV:
                begin
                    if (div_done)
                    begin
                        q_reg     <= q_cap;
                        state_reg <= S_AFIN;
                    end
                end

                S_AFIN:
                begin
                    nu_reg        <= nu_new;
                    res_relax_reg <= relax_a;
                    res_fault_reg <= 1'b0;
                    state_reg     <= S_OUT;
                end

                S_M1DIV:
                begin
                    if (div_done)
                    begin
                        if (dd == 64'sd0)
                        begin
                            res_relax_reg <= held_reg;
                            res_fault_reg <= 1'b1;
                            state_reg     <= S_OUT;
                        end
                        else
                        begin
                            dhi_reg    <= '0;
                            dlo_reg    <= TWO_60;
                            dden_reg   <= ddm;
                            neg_reg    <= dd[63];
                            state_reg  <= S_M2DIV;
                        end
                    end
                end

                S_M2DIV:
                begin
                    if (div_done)
                    begin
                        res_relax_reg <= sat32(r2);
                        res_fault_reg <= 1'b0;
                        state_reg     <= S_OUT;
                    end
                end

                S_OUT:
                begin
                    if (can_load)
                    begin
                        out_valid_reg <= 1'b1;
                        out_relax_reg <= res_relax_reg;
                        out_fault_reg <= res_fault_reg;
                        held_reg      <= res_relax_reg;
                        top_reg       <= '0;
                        den_reg       <= '0;
                        rsum_reg      <= '0;
                        cnt_reg       <= '0;
                        mark_reg      <= 1'b0;
                        rfault_reg    <= 1'b0;
                        state_reg     <= S_IDLE;
                    end
                end

                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end

    assign out_valid    = out_valid_reg;
    assign relax_factor = out_relax_reg;
    assign divide_fault = out_fault_reg;

    // divider finishes only while the sequencer waits for it
    a_div_done_wait: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> (state_reg == S_RDIV || state_reg == S_ADIV ||
                      state_reg == S_M1DIV || state_reg == S_M2DIV))
        else $error("divider result with no consumer");

    // a new result only comes from the hand-off state
    a_out_from_out: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg) == S_OUT)
        else $error("result loaded outside hand-off");

    // an init item finishes in its accept cycle
    a_init_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
        (in_acc && func == FUNC_INIT) |=> state_reg == S_IDLE)
        else $error("init item left the idle state");

endmodule

/* design/arf_ram.sv */
// generic single-port-write, single-port-read ram with registered read data
`timescale 1ns / 1ps

module arf_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

/* design/arf_div.sv */
// radix-2 restoring divider, 128-bit dividend hi:lo by 64-bit divisor, one bit a cycle
`timescale 1ns / 1ps

module arf_div (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic [arf_pkg::DIV_W-1:0] hi,
    input  logic [arf_pkg::DIV_W-1:0] lo,
    input  logic [arf_pkg::DIV_W-1:0] den,
    output logic                      done,
    output logic [arf_pkg::DIV_W-1:0] quo
);
    import arf_pkg::*;

    localparam int CW = $clog2(DIV_W);

    logic          busy_reg;
    logic          done_reg;
    logic [CW-1:0] cnt_reg;
    logic [DIV_W-1:0] rem_reg;
    logic [DIV_W-1:0] lo_reg;
    logic [DIV_W-1:0] den_reg;
    logic [DIV_W-1:0] q_reg;
    logic [DIV_W-1:0] rem_sh;
    logic [DIV_W-1:0] rem_next;
    logic             qbit;

    always_comb
    begin
        rem_sh   = {rem_reg[DIV_W-2:0], lo_reg[DIV_W-1]};
        qbit     = rem_reg[DIV_W-1] | (rem_sh >= den_reg);
        rem_next = qbit ? rem_sh - den_reg : rem_sh;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CW'(DIV_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= hi;
            lo_reg  <= lo;
            den_reg <= den;
            q_reg   <= '0;
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_next;
            lo_reg  <= {lo_reg[DIV_W-2:0], 1'b0};
            q_reg   <= {q_reg[DIV_W-2:0], qbit};
        end
    end

    assign done = done_reg;
    assign quo  = q_reg;

endmodule
